@@ hw/rtl/fpr_pkg.sv @@
// Package for the framed packet receiver: sizes, result status codes,
// sequencer step names, control word and condition flag types.
// No dependencies.
`default_nettype none

package fpr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = 6;
  localparam int LEN_W       = 7;

  localparam logic [7:0] HEAD_RESET = 8'd204;
  localparam logic [7:0] TAIL_RESET = 8'd185;

  localparam logic [1:0] ST_PKT   = 2'd0;
  localparam logic [1:0] ST_SUM   = 2'd1;
  localparam logic [1:0] ST_FRAME = 2'd2;

  typedef logic [3:0] step_t;

  localparam step_t S_HUNT    = 4'd0;
  localparam step_t S_LEN     = 4'd1;
  localparam step_t S_ID      = 4'd2;
  localparam step_t S_PAY     = 4'd3;
  localparam step_t S_TAIL    = 4'd4;
  localparam step_t S_CHECK   = 4'd5;
  localparam step_t S_SPLIT   = 4'd6;
  localparam step_t S_PREP    = 4'd7;
  localparam step_t S_EMIT    = 4'd8;
  localparam step_t S_EMPTY   = 4'd9;
  localparam step_t S_ERR_SUM = 4'd10;
  localparam step_t S_ERR_FRM = 4'd11;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_HEAD,
    C_BAD_LEN,
    C_LEN_ONE,
    C_PAY_DONE,
    C_TAIL_BAD,
    C_SUM_BAD,
    C_EMIT_LAST
  } cond_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_PKT,
    EM_EMPTY,
    EM_ERR_SUM,
    EM_ERR_FRM
  } emit_t;

  typedef struct packed {
    logic  wait_in;
    emit_t emit;
    logic  sum_clr;
    logic  len_ld;
    logic  id_ld;
    logic  sum_add;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  mem_wr;
    cond_t cond;
    step_t tgt;
    step_t nxt;
  } ctrl_word_t;

  typedef struct packed {
    logic head_hit;
    logic bad_len;
    logic len_one;
    logic pay_done;
    logic tail_bad;
    logic sum_bad;
    logic emit_last;
  } flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/framed_packet_receiver_unit.sv @@
// Top level of the framed packet receiver: datapath, payload store,
// register port and output register. Depends on fpr_pkg and fpr_sequencer.
//
//   channel  | direction | handshake        | payload
//   in_      | input     | valid / ready    | rx_byte
//   out_     | output    | valid / ready    | status, packet_id, payload_len,
//            |           |                  | has_data, byte_index,
//            |           |                  | payload_byte, last
//   cfg      | input     | APB, pready high | head_byte @0, tail_byte @4
//
// Each received byte is taken by a step of the step counter. After the
// checksum byte of a good frame, two further steps set up the store read,
// and then one result leaves per cycle while the output is not stalled; a
// single result follows an error or empty frame. Reset is synchronous and
// active low; the store is not cleared by it. No byte is taken while results
// are being sent, and a stalled output holds the sequencer on its emit step.
`default_nettype none

module framed_packet_receiver_unit import fpr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic [7:0]            out_packet_id,
  output logic [LEN_W-1:0]      out_payload_len,
  output logic                  out_has_data,
  output logic [IDX_W-1:0]      out_byte_index,
  output logic [7:0]            out_payload_byte,
  output logic                  out_last,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  ctrl_word_t cw;
  flags_t     flags;
  logic       fire;
  logic       out_free;

  logic [7:0]       head_r, tail_r;
  logic [7:0]       sum_r, len_r, id_r;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       cnt_p2;
  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       mem_rd_r;
  logic             out_valid_r;
  logic             emit_go;

  function automatic logic [7:0] bsd_add(input logic [7:0] s, input logic [7:0] b);
    return {s[0], s[7:1]} + b;
  endfunction

  fpr_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .flags    (flags),
    .cw       (cw),
    .fire     (fire)
  );

  assign in_ready = cw.wait_in;
  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = fire && (cw.emit != EM_NONE);
  assign cnt_p2   = {1'b0, cnt_r} + 8'd2;

  always_comb begin
    flags.head_hit  = (in_rx_byte == head_r);
    flags.bad_len   = (in_rx_byte == 8'd0) || (in_rx_byte > 8'(MAX_PAYLOAD + 1));
    flags.len_one   = (len_r == 8'd1);
    flags.pay_done  = (cnt_p2 >= len_r);
    flags.tail_bad  = (in_rx_byte != tail_r);
    flags.sum_bad   = (in_rx_byte != sum_r);
    flags.emit_last = (cnt_p2 == len_r);
  end

  always_comb begin
    if (fire && cw.cnt_clr) begin
      cnt_nxt = '0;
    end else if (fire && cw.cnt_inc) begin
      cnt_nxt = cnt_r + LEN_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= HEAD_RESET;
      tail_r      <= TAIL_RESET;
      sum_r       <= '0;
      len_r       <= '0;
      id_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2]) begin
          tail_r <= pwdata[7:0];
        end else begin
          head_r <= pwdata[7:0];
        end
      end
      cnt_r <= cnt_nxt;
      if (fire && cw.sum_clr) begin
        sum_r <= '0;
      end else if (fire && cw.sum_add) begin
        sum_r <= bsd_add(sum_r, in_rx_byte);
      end
      if (fire && cw.len_ld) begin
        len_r <= in_rx_byte;
      end
      if (fire && cw.id_ld) begin
        id_r <= in_rx_byte;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The read address follows the next count, so the registered data always
  // holds the entry at the current count.
  always_ff @(posedge clk) begin
    if (fire && cw.mem_wr) begin
      mem[cnt_r[IDX_W-1:0]] <= in_rx_byte;
    end
    mem_rd_r <= mem[cnt_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      unique case (cw.emit)
        EM_PKT: begin
          out_status       <= ST_PKT;
          out_packet_id    <= id_r;
          out_payload_len  <= len_r[LEN_W-1:0] - LEN_W'(1);
          out_has_data     <= 1'b1;
          out_byte_index   <= cnt_r[IDX_W-1:0];
          out_payload_byte <= mem_rd_r;
          out_last         <= flags.emit_last;
        end
        EM_EMPTY: begin
          out_status       <= ST_PKT;
          out_packet_id    <= id_r;
          out_payload_len  <= '0;
          out_has_data     <= 1'b0;
          out_byte_index   <= '0;
          out_payload_byte <= '0;
          out_last         <= 1'b1;
        end
        default: begin
          out_status       <= (cw.emit == EM_ERR_SUM) ? ST_SUM : ST_FRAME;
          out_packet_id    <= '0;
          out_payload_len  <= '0;
          out_has_data     <= 1'b0;
          out_byte_index   <= '0;
          out_payload_byte <= '0;
          out_last         <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? {24'd0, tail_r} : {24'd0, head_r};

endmodule

`default_nettype wire

@@ hw/rtl/fpr_sequencer.sv @@
// Microcode sequencer of the framed packet receiver: program table, step
// counter and conditional branch. Depends on fpr_pkg.
`default_nettype none

module fpr_sequencer import fpr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       out_free,
  input  wire flags_t     flags,
  output ctrl_word_t      cw,
  output logic            fire
);

  step_t pc_r, pc_nxt;
  logic  take;

  function automatic ctrl_word_t rom(input step_t pc);
    ctrl_word_t w;
    w = '{wait_in: 1'b0, emit: EM_NONE, sum_clr: 1'b0, len_ld: 1'b0, id_ld: 1'b0,
          sum_add: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, mem_wr: 1'b0,
          cond: C_ALWAYS, tgt: S_HUNT, nxt: S_HUNT};
    unique case (pc)
      S_HUNT: begin
        w.wait_in = 1'b1; w.sum_clr = 1'b1; w.cnt_clr = 1'b1;
        w.cond = C_HEAD; w.tgt = S_LEN; w.nxt = S_HUNT;
      end
      S_LEN: begin
        w.wait_in = 1'b1; w.len_ld = 1'b1;
        w.cond = C_BAD_LEN; w.tgt = S_ERR_FRM; w.nxt = S_ID;
      end
      S_ID: begin
        w.wait_in = 1'b1; w.id_ld = 1'b1; w.sum_add = 1'b1; w.cnt_clr = 1'b1;
        w.cond = C_LEN_ONE; w.tgt = S_TAIL; w.nxt = S_PAY;
      end
      S_PAY: begin
        w.wait_in = 1'b1; w.sum_add = 1'b1; w.mem_wr = 1'b1; w.cnt_inc = 1'b1;
        w.cond = C_PAY_DONE; w.tgt = S_TAIL; w.nxt = S_PAY;
      end
      S_TAIL: begin
        w.wait_in = 1'b1;
        w.cond = C_TAIL_BAD; w.tgt = S_ERR_FRM; w.nxt = S_CHECK;
      end
      S_CHECK: begin
        w.wait_in = 1'b1;
        w.cond = C_SUM_BAD; w.tgt = S_ERR_SUM; w.nxt = S_SPLIT;
      end
      S_SPLIT: begin
        w.cond = C_LEN_ONE; w.tgt = S_EMPTY; w.nxt = S_PREP;
      end
      S_PREP: begin
        // Rewinding the counter also starts the store read of entry zero.
        w.cnt_clr = 1'b1; w.tgt = S_EMIT;
      end
      S_EMIT: begin
        w.emit = EM_PKT; w.cnt_inc = 1'b1;
        w.cond = C_EMIT_LAST; w.tgt = S_HUNT; w.nxt = S_EMIT;
      end
      S_EMPTY:   w.emit = EM_EMPTY;
      S_ERR_SUM: w.emit = EM_ERR_SUM;
      S_ERR_FRM: w.emit = EM_ERR_FRM;
      default:   w.tgt = S_HUNT;
    endcase
    return w;
  endfunction

  assign cw = rom(pc_r);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:    take = 1'b1;
      C_HEAD:      take = flags.head_hit;
      C_BAD_LEN:   take = flags.bad_len;
      C_LEN_ONE:   take = flags.len_one;
      C_PAY_DONE:  take = flags.pay_done;
      C_TAIL_BAD:  take = flags.tail_bad;
      C_SUM_BAD:   take = flags.sum_bad;
      C_EMIT_LAST: take = flags.emit_last;
    endcase
  end

  // A step waits for a request on the input, or for room in the output
  // register, before it takes effect.
  assign fire   = (!cw.wait_in || in_valid) && ((cw.emit == EM_NONE) || out_free);
  assign pc_nxt = fire ? (take ? cw.tgt : cw.nxt) : pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_HUNT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fpr_checker.sv @@
// Port-level checker for the framed packet receiver, bound to the top level.
// Depends on fpr_pkg and framed_packet_receiver_unit.
`default_nettype none

module fpr_checker import fpr_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [1:0]       out_status,
  input wire logic [7:0]       out_packet_id,
  input wire logic [LEN_W-1:0] out_payload_len,
  input wire logic             out_has_data,
  input wire logic [IDX_W-1:0] out_byte_index,
  input wire logic [7:0]       out_payload_byte,
  input wire logic             out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_packet_id) && $stable(out_byte_index) && $stable(out_payload_byte) &&
      $stable(out_last))
    else $error("stalled result changed");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_PKT) |-> out_last && (out_packet_id == 8'd0) &&
      !out_has_data && (out_payload_len == '0))
    else $error("error result carries packet fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_PKT) || (out_status == ST_SUM) ||
      (out_status == ST_FRAME))
    else $error("undefined status code");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |-> ({1'b0, out_byte_index} < out_payload_len))
    else $error("byte index beyond payload length");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_last)
    else $error("dataless result not marked last");

endmodule

bind framed_packet_receiver_unit fpr_checker u_fpr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_packet_id    (out_packet_id),
  .out_payload_len  (out_payload_len),
  .out_has_data     (out_has_data),
  .out_byte_index   (out_byte_index),
  .out_payload_byte (out_payload_byte),
  .out_last         (out_last)
);

`default_nettype wire
